### sv/fpr_pkg.sv
// Shared constants, command/status types and helpers for the FIFO page replacement block.
`timescale 1ns / 1ps

package fpr_pkg;

   localparam int PAGE_W     = 12;                      // page number width
   localparam int PAGE_COUNT = 1 << PAGE_W;             // residency bitmap depth
   localparam int MAP_AW     = $clog2(PAGE_COUNT);      // bitmap address width
   localparam int MAX_FRAMES = 64;                      // frame ring depth
   localparam int SLOT_W     = $clog2(MAX_FRAMES);      // ring pointer width
   localparam int OCC_W      = $clog2(MAX_FRAMES + 1);  // occupancy count width
   localparam int FC_W       = 7;                       // frame_count register width
   localparam int COUNT_W    = 32;                      // fault counter width
   localparam int CSR_DW     = 32;                      // config data width
   localparam int CSR_AW     = 3;                       // config byte address width

   localparam logic [FC_W-1:0] FRAME_COUNT_RESET = FC_W'(4);

   // Register index within the config space (byte address / 4)
   localparam logic [CSR_AW-3:0] REG_FRAME_COUNT = '0;

   // Controller to datapath commands
   typedef struct packed {
      logic sweep;    // clear one bitmap entry of the power-up pass
      logic accept;   // latch the incoming item
      logic evict;    // drop the oldest page
      logic commit;   // append the new page and count the fault
      logic respond;  // launch the result
   } fpr_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic resident;    // referenced page is in the bitmap
      logic full;        // all frames in use are occupied
      logic sweep_last;  // final entry of the clearing pass
   } fpr_status_type;

   // Advance a ring pointer with wrap at the ring depth
   function automatic logic [SLOT_W-1:0] fpr_next_slot(input logic [SLOT_W-1:0] slot);
      if (slot == SLOT_W'(MAX_FRAMES - 1)) begin
         return '0;
      end
      return slot + SLOT_W'(1);
   endfunction

endpackage

### sv/fifo_page_replacement.sv
// Top level of the FIFO page replacement unit: config port, controller, datapath, checks.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive req_page_number and raise start; the item is taken at the
//   clock edge where start is high and busy is low. Busy rises after that edge.
//   Result channel: rsp_valid pulses for exactly one cycle with page_fault,
//   evicted_valid, evicted_page and fault_total. The receiver cannot hold results
//   off, so it must sample every strobe.
//   Steps per item, from the accept cycle: a hit is looked up and answered; a fault
//   with a free frame is looked up and committed; a fault that evicts a page is
//   looked up, evicts the oldest page and then commits the new one.
//   Eviction needs its own step because of the single write port of the residency
//   bitmap: clear the evicted page, then set the new one. The result strobe is
//   registered from the last work cycle and appears in the cycle after it; busy is
//   already low then, so the next item can be taken in the same cycle the result
//   appears.
//   Reset: the bitmap RAM is swept to zero, one entry per cycle, with busy held high.
//   Config writes through the APB-style port are taken at any time; the user must
//   change frame_count only while no item is in flight; the block does not enforce it.
module fifo_page_replacement
   import fpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               start,
   output logic               busy,
   input  logic [PAGE_W-1:0]  req_page_number,
   // result channel
   output logic               rsp_valid,
   output logic               rsp_page_fault,
   output logic               rsp_evicted_valid,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [COUNT_W-1:0] rsp_fault_total,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   fpr_cmd_type       cmd;
   fpr_status_type    status;
   logic [CSR_AW-3:0] reg_index;
   logic              cfg_we;
   logic [FC_W-1:0]   frame_count;

   // Decode the register index from the word address; only the access phase writes.
   assign reg_index = paddr[CSR_AW-1:2];
   assign pready    = 1'b1;
   assign cfg_we    = psel & penable & pwrite & (reg_index == REG_FRAME_COUNT);

   // Read back frame_count; unmapped words read as zero.
   always_comb begin
      prdata = '0;
      if (reg_index == REG_FRAME_COUNT) begin
         prdata = CSR_DW'(frame_count);
      end
   end

   fpr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   fpr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_page_number   (req_page_number),
      .cfg_we            (cfg_we),
      .cfg_wdata         (pwdata[FC_W-1:0]),
      .frame_count       (frame_count),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_page_fault    (rsp_page_fault),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted item");

   // Every result comes out of a cycle of work.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

   // An eviction only happens on a fault.
   a_evict_on_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted_valid) |-> rsp_page_fault)
      else $error("eviction reported on a hit");

   // A result without an eviction reports page zero.
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_page == '0))
      else $error("evicted page not zero without an eviction");

endmodule

### sv/fpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/fpr_ctrl.sv
// Controller state machine: clearing pass, lookup, eviction and commit sequencing.
`timescale 1ns / 1ps

module fpr_ctrl
   import fpr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  fpr_status_type status,
   output fpr_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && !busy_ff) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.resident) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.full) begin
               cmd.evict = 1'b1;
               state_in  = ST_EVICT;
            end else begin
               cmd.commit  = 1'b1;
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_EVICT: begin
            cmd.commit  = 1'b1;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

### sv/fpr_datapath.sv
// Datapath: frame ring, residency bitmap, pointers, counters and result registers.
`timescale 1ns / 1ps

module fpr_datapath
   import fpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  fpr_cmd_type        cmd,
   input  logic [PAGE_W-1:0]  req_page_number,
   input  logic               cfg_we,
   input  logic [FC_W-1:0]    cfg_wdata,
   output logic [FC_W-1:0]    frame_count,
   output fpr_status_type     status,
   output logic               rsp_valid,
   output logic               rsp_page_fault,
   output logic               rsp_evicted_valid,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [COUNT_W-1:0] rsp_fault_total
);

   logic [FC_W-1:0]    frame_count_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [SLOT_W-1:0]  newest_ff, newest_in;
   logic [OCC_W-1:0]   occupied_ff, occupied_in;
   logic [COUNT_W-1:0] fault_count_ff, fault_count_in;
   logic               ev_valid_ff;
   logic [PAGE_W-1:0]  ev_page_ff;
   logic [MAP_AW-1:0]  sweep_addr_ff;
   logic               rsp_valid_ff;
   logic               rsp_page_fault_ff;
   logic               rsp_evicted_valid_ff;
   logic [PAGE_W-1:0]  rsp_evicted_page_ff;
   logic [COUNT_W-1:0] rsp_fault_total_ff;

   logic [OCC_W-1:0]   frames_in_use;
   logic [SLOT_W-1:0]  append_slot;
   logic [PAGE_W-1:0]  ring_rd_data;
   logic               map_rd_data;
   logic               map_we;
   logic [MAP_AW-1:0]  map_wr_addr;
   logic               map_wr_data;

   // Clip the frame count into 1..MAX_FRAMES
   always_comb begin
      if (frame_count_ff == '0) begin
         frames_in_use = OCC_W'(1);
      end else if (frame_count_ff > FC_W'(MAX_FRAMES)) begin
         frames_in_use = OCC_W'(MAX_FRAMES);
      end else begin
         frames_in_use = OCC_W'(frame_count_ff);
      end
   end

   assign append_slot = fpr_next_slot(newest_ff);

   // Bitmap write port: clearing pass, evicted page clear, new page set
   always_comb begin
      map_we      = cmd.sweep | cmd.evict | cmd.commit;
      map_wr_data = cmd.commit;
      if (cmd.sweep) begin
         map_wr_addr = sweep_addr_ff;
      end else if (cmd.evict) begin
         map_wr_addr = MAP_AW'(ring_rd_data);
      end else begin
         map_wr_addr = MAP_AW'(page_ff);
      end
   end

   fpr_ram #(
      .WIDTH(1),
      .DEPTH(PAGE_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (MAP_AW'(req_page_number)),
      .rd_data (map_rd_data)
   );

   fpr_ram #(
      .WIDTH(PAGE_W),
      .DEPTH(MAX_FRAMES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (append_slot),
      .wr_data (page_ff),
      .rd_addr (oldest_ff),
      .rd_data (ring_rd_data)
   );

   always_comb begin
      oldest_in      = oldest_ff;
      newest_in      = newest_ff;
      occupied_in    = occupied_ff;
      fault_count_in = fault_count_ff;
      if (cmd.evict) begin
         oldest_in   = fpr_next_slot(oldest_ff);
         occupied_in = occupied_ff - OCC_W'(1);
      end else if (cmd.commit) begin
         newest_in   = append_slot;
         occupied_in = occupied_ff + OCC_W'(1);
         if (fault_count_ff != '1) begin
            fault_count_in = fault_count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
         oldest_ff      <= '0;
         newest_ff      <= SLOT_W'(MAX_FRAMES - 1);
         occupied_ff    <= '0;
         fault_count_ff <= '0;
         sweep_addr_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cfg_we) begin
            frame_count_ff <= cfg_wdata;
         end
         oldest_ff      <= oldest_in;
         newest_ff      <= newest_in;
         occupied_ff    <= occupied_in;
         fault_count_ff <= fault_count_in;
         if (cmd.sweep) begin
            sweep_addr_ff <= sweep_addr_ff + MAP_AW'(1);
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         page_ff     <= req_page_number;
         ev_valid_ff <= 1'b0;
         ev_page_ff  <= '0;
      end else if (cmd.evict) begin
         ev_valid_ff <= 1'b1;
         ev_page_ff  <= ring_rd_data;
      end
      if (cmd.respond) begin
         rsp_page_fault_ff    <= cmd.commit;
         rsp_evicted_valid_ff <= ev_valid_ff;
         rsp_evicted_page_ff  <= ev_page_ff;
         rsp_fault_total_ff   <= fault_count_in;
      end
   end

   assign status.resident   = map_rd_data;
   assign status.full       = (occupied_ff >= frames_in_use);
   assign status.sweep_last = (sweep_addr_ff == MAP_AW'(PAGE_COUNT - 1));

   assign frame_count       = frame_count_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_page_fault    = rsp_page_fault_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_total   = rsp_fault_total_ff;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the FIFO page replacement unit: directed and random references.
`timescale 1ns / 1ps

module tb_top;
   import fpr_pkg::*;

   // Generous bound: clearing pass plus ~430 items at worst-case gap and latency,
   // several times over.
   localparam int CYCLE_LIMIT   = 200000;
   // Idle cycles after the last result before a register write or the verdict.
   localparam int SETTLE_CYCLES = 8;
   // Register index that decodes to nothing (byte address 4).
   localparam logic [CSR_AW-3:0] REG_UNMAPPED = 1'b1;

   // One result item: what a single page reference produces.
   typedef struct packed {
      logic               fault;
      logic               evicted;
      logic [PAGE_W-1:0]  victim;
      logic [COUNT_W-1:0] total;
   } page_outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [PAGE_W-1:0]  req_page_number = '0;
   logic               rsp_valid;
   logic               rsp_page_fault;
   logic               rsp_evicted_valid;
   logic [PAGE_W-1:0]  rsp_evicted_page;
   logic [COUNT_W-1:0] rsp_fault_total;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_AW-1:0]  paddr = '0;
   logic [CSR_DW-1:0]  pwdata = '0;
   logic [CSR_DW-1:0]  prdata;
   logic               pready;

   // Shadow of the block's replacement state, updated at each accepted item.
   logic [FC_W-1:0]    frame_setting = FRAME_COUNT_RESET;
   logic [PAGE_W-1:0]  ring_pages [MAX_FRAMES];
   int                 oldest_idx = 0;
   int                 newest_idx = MAX_FRAMES - 1;
   int                 occupancy = 0;
   bit                 resident_pages [PAGE_COUNT];
   logic [COUNT_W-1:0] faults_seen = '0;

   page_outcome_type   pending_outcomes [$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;

   fifo_page_replacement u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_page_fault    (rsp_page_fault),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Out-of-range frame settings clamp to 1..MAX_FRAMES.
   function automatic int frames_active(input logic [FC_W-1:0] setting);
      if (setting == '0) begin
         return 1;
      end
      if (setting > MAX_FRAMES) begin
         return MAX_FRAMES;
      end
      return int'(setting);
   endfunction

   // Apply one page reference to the shadow state and return its outcome.
   function automatic page_outcome_type resolve_page_reference(input logic [PAGE_W-1:0] page);
      page_outcome_type outcome;
      outcome = '0;
      if (!resident_pages[page]) begin
         outcome.fault = 1'b1;
         // Evict exactly one oldest page; extra pages left by a shrink stay put.
         if (occupancy >= frames_active(frame_setting)) begin
            outcome.evicted = 1'b1;
            outcome.victim  = ring_pages[oldest_idx];
            resident_pages[ring_pages[oldest_idx]] = 1'b0;
            oldest_idx = (oldest_idx + 1) % MAX_FRAMES;
            occupancy--;
         end
         newest_idx = (newest_idx + 1) % MAX_FRAMES;
         ring_pages[newest_idx] = page;
         occupancy++;
         resident_pages[page] = 1'b1;
         if (faults_seen != '1) begin
            faults_seen++;
         end
      end
      outcome.total = faults_seen;
      return outcome;
   endfunction

   // Cycle bound: any hang ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic compare_field(input string name, input logic [COUNT_W-1:0] want,
                                input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
         mismatch_count++;
      end
   endtask

   // Check every result strobe against the oldest expected outcome.
   always @(posedge clock) begin : result_check
      page_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %0b %0b %0h %0h",
                     $realtime, rsp_page_fault, rsp_evicted_valid, rsp_evicted_page,
                     rsp_fault_total);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("page_fault", COUNT_W'(want.fault), COUNT_W'(rsp_page_fault));
            compare_field("evicted_valid", COUNT_W'(want.evicted),
                          COUNT_W'(rsp_evicted_valid));
            compare_field("evicted_page", COUNT_W'(want.victim), COUNT_W'(rsp_evicted_page));
            compare_field("fault_total", want.total, rsp_fault_total);
         end
      end
   end

   // Present one page reference; hold it until the block takes it.
   task automatic send_page(input logic [PAGE_W-1:0] page);
      @(negedge clock);
      start = 1'b1;
      req_page_number = page;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_outcomes.push_back(resolve_page_reference(page));
   endtask

   task automatic idle_cycles(input int count);
      repeat (count) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Drop start, wait out every expected result, then let the block settle.
   task automatic wait_for_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_AW-3:0] index,
                                 input logic [CSR_DW-1:0] value);
      @(negedge clock);
      start   = 1'b0;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      if (index == REG_FRAME_COUNT) begin
         frame_setting = value[FC_W-1:0];
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Reprogram the frame count once idle; upper data bits carry noise.
   task automatic set_frame_count(input logic [FC_W-1:0] setting);
      logic [CSR_DW-1:0] value;
      value = $urandom;
      value[FC_W-1:0] = setting;
      wait_for_results();
      write_register(REG_FRAME_COUNT, value);
   endtask

   // Reset frame count of four: fill, hit, and the first eviction; page extremes.
   task automatic test_page_extremes();
      send_page(12'h000);
      send_page(12'hFFF);
      send_page(12'hAAA);
      send_page(12'h555);
      send_page(12'h000);
      send_page(12'hFFF);
      send_page(12'h001);
   endtask

   // Zero acts as one frame, values above the ring depth act as the full ring.
   task automatic test_frame_count_limits();
      set_frame_count('0);
      send_page(12'h123);
      send_page(12'h555);
      set_frame_count('1);
      send_page(12'h7FF);
      send_page(12'h400);
   endtask

   // Shrink while occupied: each fault evicts one oldest page, the rest stay resident.
   task automatic test_frame_count_shrink();
      set_frame_count(FC_W'(2));
      send_page(12'h800);
      send_page(12'h801);
      send_page(12'h802);
      send_page(12'h400);
   endtask

   // A write to an unmapped index must leave the frame count alone.
   task automatic test_unmapped_register();
      wait_for_results();
      write_register(REG_UNMAPPED, CSR_DW'(1));
      send_page(12'h803);
      send_page(12'h7FF);
   endtask

   // One phase: a working set a bit larger than the frames, plus full-range noise.
   task automatic run_random_phase(input logic [FC_W-1:0] setting, input int items,
                                   input bit with_gaps);
      logic [PAGE_W-1:0] working_set [MAX_FRAMES + 8];
      int                set_size;
      bit                bursty;
      logic [PAGE_W-1:0] page;
      set_frame_count(setting);
      set_size = frames_active(setting) + $urandom_range(1, 8);
      foreach (working_set[i]) begin
         working_set[i] = PAGE_W'($urandom);
      end
      bursty = 1'b0;
      for (int n = 0; n < items; n++) begin
         // Alternate stretches with and without sender gaps.
         if (n % 16 == 0) begin
            bursty = with_gaps && ($urandom_range(0, 2) != 0);
         end
         if (bursty && $urandom_range(0, 2) == 0) begin
            idle_cycles($urandom_range(1, 7));
         end
         if ($urandom_range(0, 4) == 0) begin
            page = PAGE_W'($urandom);
         end else begin
            page = working_set[$urandom_range(0, set_size - 1)];
         end
         send_page(page);
      end
   endtask

   // Sweep the frame count across its extremes; the last phase runs back to back.
   task automatic test_random_traffic();
      run_random_phase(FC_W'(1), 60, 1'b1);
      run_random_phase(FC_W'(MAX_FRAMES), 80, 1'b1);
      run_random_phase('0, 40, 1'b1);
      run_random_phase('1, 60, 1'b1);
      run_random_phase(FC_W'($urandom_range(2, MAX_FRAMES - 1)), 60, 1'b1);
      run_random_phase(FC_W'($urandom_range(MAX_FRAMES + 1, 126)), 40, 1'b1);
      run_random_phase(FC_W'($urandom_range(1, MAX_FRAMES)), 60, 1'b0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_page_extremes();
      test_frame_count_limits();
      test_frame_count_shrink();
      test_unmapped_register();
      test_random_traffic();
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### fifo_page_replacement.f
sv/fpr_pkg.sv
sv/fpr_ram.sv
sv/fpr_ctrl.sv
sv/fpr_datapath.sv
sv/fifo_page_replacement.sv
sim/tb_top.sv
